// File: rtl/pcd_pkg.sv
// pcd_pkg: shared types and constants for the png chunk deframer
// holds the input and result transaction structs, role/error/phase codes
// and the png signature lookup; no dependencies
package pcd_pkg;

  // byte roles reported with each result
  localparam logic [2:0] ROLE_SIG  = 3'd0;
  localparam logic [2:0] ROLE_LEN  = 3'd1;
  localparam logic [2:0] ROLE_TYPE = 3'd2;
  localparam logic [2:0] ROLE_DATA = 3'd3;
  localparam logic [2:0] ROLE_CRC  = 3'd4;
  localparam logic [2:0] ROLE_ERR  = 3'd5;

  // parser phases, coded to match the role of the byte taken in that phase
  localparam logic [2:0] PH_SIG  = ROLE_SIG;
  localparam logic [2:0] PH_LEN  = ROLE_LEN;
  localparam logic [2:0] PH_TYPE = ROLE_TYPE;
  localparam logic [2:0] PH_DATA = ROLE_DATA;
  localparam logic [2:0] PH_CRC  = ROLE_CRC;
  localparam logic [2:0] PH_ERR  = ROLE_ERR;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_BADSIG = 2'd1;
  localparam logic [1:0] ERR_TRUNC  = 2'd2;

  // signature and chunk field sizes
  localparam int unsigned SIG_BYTES   = 8;
  localparam int unsigned FIELD_BYTES = 4;

  // one input transaction
  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_start;
    logic       file_last;
  } in_t;

  // one result transaction
  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  data_byte;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic [31:0] chunk_crc;
    logic        chunk_end;
    logic [1:0]  error_code;
  } out_t;

  // expected png signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'h89;
      3'd1: val = 8'h50;
      3'd2: val = 8'h4E;
      3'd3: val = 8'h47;
      3'd4: val = 8'h0D;
      3'd5: val = 8'h0A;
      3'd6: val = 8'h1A;
      3'd7: val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/pcd_parser.sv
// pcd_parser: per-byte parse state and result computation
// keeps phase, byte counter and the length/type/crc accumulators
// depends on pcd_pkg
module pcd_parser import pcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  in_t  in_data,
  output out_t result
);

  logic [2:0]  phase;
  logic [31:0] byte_count;
  logic [31:0] length_acc;
  logic [31:0] type_acc;
  logic [31:0] crc_acc;

  logic [2:0]  phase_next;
  logic [31:0] byte_count_next;
  logic [31:0] length_acc_next;
  logic [31:0] type_acc_next;
  logic [31:0] crc_acc_next;

  logic [2:0]  cur_phase;
  logic [31:0] cur_count;
  logic [31:0] count_inc;
  logic [7:0]  b;
  logic [2:0]  role;
  logic [1:0]  err;
  logic        end_flag;

  // next state and result for the byte at the input
  always_comb begin
    b         = in_data.file_byte;
    cur_phase = in_data.file_start ? PH_SIG : phase;
    cur_count = in_data.file_start ? 32'd0 : byte_count;
    length_acc_next = in_data.file_start ? 32'd0 : length_acc;
    type_acc_next   = in_data.file_start ? 32'd0 : type_acc;
    crc_acc_next    = in_data.file_start ? 32'd0 : crc_acc;
    count_inc       = cur_count + 32'd1;
    phase_next      = cur_phase;
    byte_count_next = count_inc;
    role     = ROLE_ERR;
    err      = ERR_NONE;
    end_flag = 1'b0;

    unique case (cur_phase)
      PH_SIG: begin
        role = ROLE_SIG;
        if (b != sig_byte(cur_count[2:0])) begin
          err             = ERR_BADSIG;
          phase_next      = PH_ERR;
          byte_count_next = 32'd0;
        end else if (cur_count[2:0] == 3'(SIG_BYTES - 1)) begin
          phase_next      = PH_LEN;
          byte_count_next = 32'd0;
        end
      end
      PH_LEN: begin
        role = ROLE_LEN;
        if (cur_count == 32'd0) begin
          length_acc_next = 32'd0;
          type_acc_next   = 32'd0;
          crc_acc_next    = 32'd0;
        end
        length_acc_next = {length_acc_next[23:0], b};
        if (cur_count[1:0] == 2'(FIELD_BYTES - 1)) begin
          phase_next      = PH_TYPE;
          byte_count_next = 32'd0;
        end
      end
      PH_TYPE: begin
        role          = ROLE_TYPE;
        type_acc_next = {type_acc_next[23:0], b};
        if (cur_count[1:0] == 2'(FIELD_BYTES - 1)) begin
          phase_next      = (length_acc_next == 32'd0) ? PH_CRC : PH_DATA;
          byte_count_next = 32'd0;
        end
      end
      PH_DATA: begin
        role = ROLE_DATA;
        if (count_inc >= length_acc_next) begin
          phase_next      = PH_CRC;
          byte_count_next = 32'd0;
        end
      end
      PH_CRC: begin
        role         = ROLE_CRC;
        crc_acc_next = {crc_acc_next[23:0], b};
        if (cur_count[1:0] == 2'(FIELD_BYTES - 1)) begin
          end_flag        = 1'b1;
          phase_next      = PH_LEN;
          byte_count_next = 32'd0;
        end
      end
      default: begin
        role            = ROLE_ERR;
        err             = ERR_BADSIG;
        byte_count_next = cur_count;
      end
    endcase

    // result fields, accumulators hidden in signature and error roles
    result.byte_role  = role;
    result.data_byte  = b;
    result.chunk_end  = end_flag;
    if (role == ROLE_SIG || role == ROLE_ERR) begin
      result.chunk_length = 32'd0;
      result.chunk_type   = 32'd0;
      result.chunk_crc    = 32'd0;
    end else begin
      result.chunk_length = length_acc_next;
      result.chunk_type   = type_acc_next;
      result.chunk_crc    = crc_acc_next;
    end

    // file end: flag truncation unless a chunk or the signature just closed
    if (in_data.file_last) begin
      if (err == ERR_NONE && !(phase_next == PH_LEN && byte_count_next == 32'd0)) begin
        err = ERR_TRUNC;
      end
      phase_next      = PH_SIG;
      byte_count_next = 32'd0;
      length_acc_next = 32'd0;
      type_acc_next   = 32'd0;
      crc_acc_next    = 32'd0;
    end
    result.error_code = err;
  end

  // state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIG;
      byte_count <= 32'd0;
      length_acc <= 32'd0;
      type_acc   <= 32'd0;
      crc_acc    <= 32'd0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      length_acc <= length_acc_next;
      type_acc   <= type_acc_next;
      crc_acc    <= crc_acc_next;
    end
  end

endmodule

// File: rtl/pcd_out_buf.sv
// pcd_out_buf: result register with a skid stage
// decouples the output handshake from input acceptance
// depends on pcd_pkg
module pcd_out_buf import pcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  out_t push_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic main_valid;
  logic skid_valid;
  out_t main_data;
  out_t skid_data;
  logic push;

  assign push_ready = ~skid_valid;
  assign push       = push_valid & ~skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  // control: main register refills from skid first, then from the push side
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: rtl/png_chunk_deframer_core.sv
// png_chunk_deframer_core: top level of the png chunk deframer
// a png file enters one byte per transaction on the in channel; each byte
// yields one result transaction on the out channel naming its role
// (signature, length, type, data, crc, or ignored after a bad signature),
// passing the byte through and reporting length, type and crc as collected.
// both channels are valid/ready; in_data and out_data are packed structs.
// a byte's result is registered in the result register, or in the skid
// stage while the receiver stalls, before it shows on out_data. throughput: one
// byte per cycle while the receiver takes results, set by the single state update in the parser.
// file_start restarts parsing on its byte; after a file_last byte the
// parser returns to the signature phase on its own.
// reset (rst, synchronous) puts the parser in the signature phase with
// cleared counters and empties the result register and skid stage.
// when the receiver stalls, one more byte is held in the skid stage; then
// in_ready drops until the result register drains.
// depends on pcd_pkg, pcd_parser, pcd_out_buf
module png_chunk_deframer_core import pcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  out_t result;
  logic accept;

  assign accept = in_valid & in_ready;

  // parse state and per-byte result
  pcd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .result  (result)
  );

  // result register and skid stage
  pcd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: test/pcd_checker.sv
// pcd_checker: watches both channels of the png chunk deframer, predicts every
// result transaction from the accepted bytes and compares them field by field
// depends on pcd_pkg for the transaction structs and the role/phase/error codes
module pcd_checker import pcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   chunk_ends
);

  // png signature as the parser expects it
  localparam logic [7:0] SIG_SEQ [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                         8'h0D, 8'h0A, 8'h1A, 8'h0A};

  // predicted parser state
  logic [2:0]  ph;
  logic [31:0] cnt;
  logic [31:0] len_acc;
  logic [31:0] type_acc;
  logic [31:0] crc_acc;
  logic        bad_sig;

  // results predicted but not yet seen on the out channel
  out_t pending_results[$];

  task automatic clear_parser();
    ph       = PH_SIG;
    cnt      = '0;
    len_acc  = '0;
    type_acc = '0;
    crc_acc  = '0;
    bad_sig  = 1'b0;
  endtask

  // one line per mismatch, printing capped so a broken block stays readable
  task automatic report(input string what);
    if (fail_count < 30) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %h, want %h", name, got, want));
    end
  endtask

  // advance the predicted parser by one byte and form its result
  task automatic parse_byte(input in_t t, output out_t r);
    logic [2:0] role;
    logic [1:0] err;
    logic       fin;
    role = ROLE_SIG;
    err  = ERR_NONE;
    fin  = 1'b0;
    if (t.file_start) begin
      clear_parser();
    end
    case (ph)
      PH_SIG: begin
        role = ROLE_SIG;
        if (t.file_byte != SIG_SEQ[cnt[2:0]]) begin
          err     = ERR_BADSIG;
          bad_sig = 1'b1;
          ph      = PH_ERR;
          cnt     = '0;
        end else begin
          cnt = cnt + 1;
          if (cnt >= SIG_BYTES) begin
            ph  = PH_LEN;
            cnt = '0;
          end
        end
      end
      PH_LEN: begin
        role = ROLE_LEN;
        // first length byte opens a new chunk
        if (cnt == 0) begin
          len_acc  = '0;
          type_acc = '0;
          crc_acc  = '0;
        end
        len_acc = {len_acc[23:0], t.file_byte};
        cnt     = cnt + 1;
        if (cnt >= FIELD_BYTES) begin
          ph  = PH_TYPE;
          cnt = '0;
        end
      end
      PH_TYPE: begin
        role     = ROLE_TYPE;
        type_acc = {type_acc[23:0], t.file_byte};
        cnt      = cnt + 1;
        if (cnt >= FIELD_BYTES) begin
          // empty chunks skip straight to the crc
          ph  = (len_acc == 0) ? PH_CRC : PH_DATA;
          cnt = '0;
        end
      end
      PH_DATA: begin
        role = ROLE_DATA;
        cnt  = cnt + 1;
        if (cnt >= len_acc) begin
          ph  = PH_CRC;
          cnt = '0;
        end
      end
      PH_CRC: begin
        role    = ROLE_CRC;
        crc_acc = {crc_acc[23:0], t.file_byte};
        cnt     = cnt + 1;
        if (cnt >= FIELD_BYTES) begin
          fin = 1'b1;
          ph  = PH_LEN;
          cnt = '0;
        end
      end
      default: begin
        role = ROLE_ERR;
        err  = ERR_BADSIG;
      end
    endcase
    r.byte_role = role;
    r.data_byte = t.file_byte;
    r.chunk_end = fin;
    if (role == ROLE_SIG || role == ROLE_ERR) begin
      r.chunk_length = '0;
      r.chunk_type   = '0;
      r.chunk_crc    = '0;
    end else begin
      r.chunk_length = len_acc;
      r.chunk_type   = type_acc;
      r.chunk_crc    = crc_acc;
    end
    // end of file anywhere but a signature or chunk boundary is truncation
    if (t.file_last) begin
      if (err == ERR_NONE && !(ph == PH_LEN && cnt == 0)) begin
        err = ERR_TRUNC;
      end
      clear_parser();
    end
    r.error_code = err;
  endtask

  // compare results first, so a result never meets a byte of the same edge
  always @(posedge clk) begin
    out_t want;
    out_t next_r;
    if (rst) begin
      clear_parser();
      pending_results.delete();
      fail_count   = 0;
      results_seen = 0;
      chunk_ends   = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report($sformatf("result with nothing pending, role %0d byte %h",
                           out_data.byte_role, out_data.data_byte));
        end else begin
          want = pending_results.pop_front();
          check_field("byte_role", 32'(out_data.byte_role), 32'(want.byte_role));
          check_field("data_byte", 32'(out_data.data_byte), 32'(want.data_byte));
          check_field("chunk_length", out_data.chunk_length, want.chunk_length);
          check_field("chunk_type", out_data.chunk_type, want.chunk_type);
          check_field("chunk_crc", out_data.chunk_crc, want.chunk_crc);
          check_field("chunk_end", 32'(out_data.chunk_end), 32'(want.chunk_end));
          check_field("error_code", 32'(out_data.error_code), 32'(want.error_code));
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_data, next_r);
        if (next_r.chunk_end) begin
          chunk_ends++;
        end
        pending_results.push_back(next_r);
      end
    end
    pending = pending_results.size();
  end

endmodule

// File: test/png_chunk_deframer_core_tb.sv
// png_chunk_deframer_core_tb: builds png-like files, well-formed and broken,
// and streams them into the deframer with random gaps and output stalls
// depends on pcd_pkg, png_chunk_deframer_core and pcd_checker
module png_chunk_deframer_core_tb;
  import pcd_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int TARGET_BYTES = 1350;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int fail_count;
  int pending;
  int results_seen;
  int chunk_ends;

  // no gaps and no stalls while set
  logic calm;

  logic [7:0] fbytes[$];
  int  n_files;
  int  n_bytes;
  bit  need_start;

  png_chunk_deframer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pcd_checker u_pcd_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .chunk_ends   (chunk_ends)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls in runs
  initial begin
    int run;
    logic lvl;
    out_ready = 1'b0;
    run = 0;
    lvl = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        lvl = ($urandom_range(0, 99) < 65);
        run = lvl ? $urandom_range(1, 12) : pick_gap();
        if (run == 0) begin
          run = 1;
          lvl = 1'b1;
        end
      end
      out_ready <= calm ? 1'b1 : lvl;
      run--;
    end
  end

  // watchdog: cycles with no transaction on either channel
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // one byte transaction, entered and left at a falling edge
  task automatic drive_byte(input in_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // send the built file, marking its first and last bytes as asked
  task automatic drive_file(input bit with_start, input bit with_last);
    in_t t;
    for (int i = 0; i < fbytes.size(); i++) begin
      t.file_byte  = fbytes[i];
      t.file_start = with_start && (i == 0);
      t.file_last  = with_last && (i == fbytes.size() - 1);
      drive_byte(t);
    end
    n_bytes += fbytes.size();
    n_files++;
    fbytes.delete();
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) begin
      fbytes.push_back(w[i*8 +: 8]);
    end
  endtask

  task automatic push_sig();
    push_word(32'h89504E47);
    push_word(32'h0D0A1A0A);
  endtask

  // chunk header, body bytes (possibly fewer than len) and crc
  task automatic push_chunk(input logic [31:0] len, input int body);
    push_word(len);
    push_word($urandom());
    for (int i = 0; i < body; i++) begin
      fbytes.push_back(8'($urandom_range(0, 255)));
    end
    push_word($urandom());
  endtask

  // keep only the first keep bytes of the built file
  task automatic cut_file(input int keep);
    while (fbytes.size() > keep) fbytes.pop_back();
  endtask

  // stimulus
  initial begin
    int kind;
    int nch;
    int c;
    int pos;
    bit st;
    bit big;
    logic [31:0] len;
    logic [7:0] flip;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    calm       = 1'b0;
    n_files    = 0;
    n_bytes    = 0;
    need_start = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // bad first byte, ignored tail, end of file while ignoring
    fbytes = '{8'h00, 8'hFF, 8'h89};
    drive_file(1'b1, 1'b1);
    // file abandoned by a new start marker, then truncated in the signature
    fbytes = '{8'h89};
    drive_file(1'b1, 1'b0);
    fbytes = '{8'h89, 8'h50};
    drive_file(1'b1, 1'b1);
    // complete file with one empty chunk, all-ones type
    push_sig();
    push_word(32'h00000000);
    push_word(32'hFFFFFFFF);
    push_word(32'hFF00FF00);
    drive_file(1'b1, 1'b1);

    // random files
    while (n_bytes < TARGET_BYTES) begin
      calm = ($urandom_range(0, 99) < 12);
      kind = $urandom_range(0, 99);
      st = need_start ? 1'b1 : ($urandom_range(0, 3) != 0);
      need_start = 1'b0;
      if (kind < 65) begin
        // well-formed file, sometimes cut short or abandoned
        push_sig();
        nch = $urandom_range(1, 3);
        big = 1'b0;
        for (int k = 0; k < nch && !big; k++) begin
          c = $urandom_range(0, 99);
          if (c < 85) begin
            len = $urandom_range(0, 6);
            push_chunk(len, len);
          end else if (c < 95) begin
            len = $urandom_range(7, 24);
            push_chunk(len, len);
          end else begin
            len = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : ($urandom() | 32'h01000000);
            big = 1'b1;
            push_chunk(len, $urandom_range(0, 5));
          end
        end
        c = $urandom_range(0, 99);
        if (c < 10) begin
          cut_file($urandom_range(1, fbytes.size()));
          need_start = 1'b1;
          drive_file(st, 1'b0);
        end else if (big || c < 25) begin
          // big chunks never complete, so their crc bytes are dropped
          pos = big ? fbytes.size() - 4 : fbytes.size();
          cut_file($urandom_range(1, pos));
          drive_file(st, 1'b1);
        end else begin
          drive_file(st, 1'b1);
        end
      end else if (kind < 78) begin
        // one signature byte corrupted, then whatever follows
        push_sig();
        pos = $urandom_range(0, 7);
        flip = 8'($urandom_range(1, 255));
        fbytes[pos] = fbytes[pos] ^ flip;
        if ($urandom_range(0, 1) != 0) begin
          push_chunk(2, 2);
        end
        c = $urandom_range(0, 6);
        for (int i = 0; i < c; i++) begin
          fbytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0) begin
          need_start = 1'b1;
          drive_file(st, 1'b0);
        end else begin
          drive_file(st, 1'b1);
        end
      end else if (kind < 88) begin
        // noise
        c = $urandom_range(1, 16);
        for (int i = 0; i < c; i++) begin
          fbytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) != 0) begin
          drive_file(st, 1'b1);
        end else begin
          need_start = 1'b1;
          drive_file(st, 1'b0);
        end
      end else begin
        // file that ends right after its signature
        push_sig();
        drive_file(st, 1'b1);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain and let the pipeline settle
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d files, %0d bytes sent", n_files, n_bytes);
    $display("%0d results compared, %0d chunk ends, %0d mismatches",
             results_seen, chunk_ends, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
